// ===== design/efc_pkg.sv =====
// Shared types and constants of the elevator floor controller.
// Depends on nothing; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package efc_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_CLOSE = 3'd1,
      MODE_MOVE  = 3'd2,
      MODE_OPEN  = 3'd3,
      MODE_SPEED = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_CALL = 2'd1,
      OP_MODE = 2'd2,
      OP_ADC  = 2'd3
   } opcode_type;

   // Register indexes on the configuration port (byte address = 4 * index).
   localparam logic [1:0] REG_DOOR_DELAY = 2'd0;
   localparam logic [1:0] REG_BLINK      = 2'd1;
   localparam logic [1:0] REG_MOVE_BASE  = 2'd2;
   localparam logic [1:0] REG_MOVE_STEP  = 2'd3;

   // Speed selection: index = ceil(2 * sample / 341), samples below ADC_MIN give 0.
   localparam logic [9:0]  ADC_MIN       = 10'd5;
   localparam logic [10:0] ADC_STEP_X2   = 11'd341;
   localparam int          SPEED_STEPS   = 6;
   localparam logic [2:0]  SPEED_RESET   = 3'd6;

   typedef struct packed {
      logic [11:0] door_delay;
      logic [9:0]  blink;
      logic [11:0] move_base;
      logic [9:0]  move_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      door_delay: 12'd1500,
      blink:      10'd200,
      move_base:  12'd400,
      move_step:  10'd100
   };

   typedef struct packed {
      mode_type    mode;
      mode_type    saved_mode;
      logic [1:0]  floor_no;
      logic [1:0]  target;
      logic [1:0]  pending;
      logic [11:0] door_timer;
      logic [9:0]  blink_timer;
      logic [13:0] travel_timer;
      logic        down;
      logic        door_led;
      logic        motion_led;
      logic [2:0]  speed;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:         MODE_IDLE,
      saved_mode:   MODE_IDLE,
      floor_no:     2'd1,
      target:       2'd0,
      pending:      2'd0,
      door_timer:   12'd0,
      blink_timer:  10'd0,
      travel_timer: 14'd0,
      down:         1'b0,
      door_led:     1'b0,
      motion_led:   1'b0,
      speed:        SPEED_RESET
   };

endpackage

// ===== design/efc_csr.sv =====
// Configuration registers of the elevator floor controller behind an APB-style port.
// Depends on efc_pkg for the register layout, indexes and reset values.
`timescale 1ns / 1ps

module efc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output efc_pkg::cfg_type cfg
);

   efc_pkg::cfg_type cfg_ff;
   efc_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            efc_pkg::REG_DOOR_DELAY: cfg_in.door_delay = pwdata[11:0];
            efc_pkg::REG_BLINK:      cfg_in.blink      = pwdata[9:0];
            efc_pkg::REG_MOVE_BASE:  cfg_in.move_base  = pwdata[11:0];
            efc_pkg::REG_MOVE_STEP:  cfg_in.move_step  = pwdata[9:0];
            default:                 cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= efc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         efc_pkg::REG_DOOR_DELAY: prdata = {20'd0, cfg_ff.door_delay};
         efc_pkg::REG_BLINK:      prdata = {22'd0, cfg_ff.blink};
         efc_pkg::REG_MOVE_BASE:  prdata = {20'd0, cfg_ff.move_base};
         efc_pkg::REG_MOVE_STEP:  prdata = {22'd0, cfg_ff.move_step};
         default:                 prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/efc_step.sv =====
// One-event state update of the elevator floor controller (combinational).
// Depends on efc_pkg for the state, configuration and code types.
`timescale 1ns / 1ps

module efc_step #(
   parameter int NUM_FLOORS = 3
) (
   input  efc_pkg::state_type cur,
   input  efc_pkg::cfg_type   cfg,
   input  logic [1:0]         opcode,
   input  logic [1:0]         call_floor,
   input  logic [9:0]         adc_sample,
   output efc_pkg::state_type nxt,
   output logic [1:0]         shown
);

   efc_pkg::opcode_type op;
   efc_pkg::mode_type   mode_nxt;
   logic                door_phase;
   logic                door_done;
   logic [13:0]         period;
   logic                travel_due;
   logic                go_down;
   logic                go_up;
   logic                call_ok;
   logic [10:0]         adc_x2;
   logic [2:0]          speed_pick;

   assign op         = efc_pkg::opcode_type'(opcode);
   assign door_phase = cur.mode inside {efc_pkg::MODE_CLOSE, efc_pkg::MODE_OPEN};
   assign door_done  = (cur.door_timer == cfg.door_delay);
   assign period     = 14'(cfg.move_base) + 14'(cfg.move_step) * 14'(cur.speed);
   assign travel_due = (cur.travel_timer >= period);
   assign go_down    = (cur.target != 2'd0) && (cur.target < cur.floor_no);
   assign go_up      = (cur.target > cur.floor_no);
   assign call_ok    = (call_floor != 2'd0) && (32'(call_floor) <= 32'(NUM_FLOORS));
   assign adc_x2     = {adc_sample, 1'b0};

   // Count the speed thresholds the sample has passed.
   always_comb begin
      speed_pick = 3'd0;
      for (int k = 0; k < efc_pkg::SPEED_STEPS; k++) begin
         if (adc_x2 > 11'(k) * efc_pkg::ADC_STEP_X2) begin
            speed_pick = speed_pick + 3'd1;
         end
      end
   end

   // Next mode.
   always_comb begin
      mode_nxt = cur.mode;
      case (op)
         efc_pkg::OP_TICK: begin
            case (cur.mode)
               efc_pkg::MODE_CLOSE: begin
                  if (door_done) mode_nxt = efc_pkg::MODE_MOVE;
               end
               efc_pkg::MODE_OPEN: begin
                  if (door_done) begin
                     mode_nxt = (cur.floor_no != cur.target) ? efc_pkg::MODE_CLOSE
                                                             : efc_pkg::MODE_IDLE;
                  end
               end
               efc_pkg::MODE_MOVE: begin
                  if (!go_down && !go_up) mode_nxt = efc_pkg::MODE_OPEN;
               end
               default: mode_nxt = cur.mode;
            endcase
         end
         efc_pkg::OP_CALL: begin
            if (call_ok && cur.mode == efc_pkg::MODE_IDLE && cur.floor_no != call_floor) begin
               mode_nxt = efc_pkg::MODE_CLOSE;
            end
         end
         efc_pkg::OP_MODE: begin
            mode_nxt = (cur.mode != efc_pkg::MODE_SPEED) ? efc_pkg::MODE_SPEED
                                                         : cur.saved_mode;
         end
         default: mode_nxt = cur.mode;
      endcase
   end

   // Timers, LEDs, floors and speed.
   always_comb begin
      logic [9:0]  blink_t;
      logic [11:0] door_t;
      logic [13:0] travel_t;
      logic        led_t;

      nxt      = cur;
      nxt.mode = mode_nxt;
      blink_t  = cur.blink_timer;
      door_t   = cur.door_timer;
      travel_t = cur.travel_timer;
      led_t    = 1'b0;

      case (op)
         efc_pkg::OP_TICK: begin
            if (door_phase) begin
               blink_t = door_done ? 10'd0 : cur.blink_timer;
               door_t  = door_done ? 12'd0 : cur.door_timer;
               led_t   = door_done ? 1'b0  : cur.door_led;
               if (blink_t == cfg.blink) begin
                  led_t   = ~led_t;
                  blink_t = 10'd0;
               end
               nxt.door_led    = led_t;
               nxt.door_timer  = door_t + 12'd1;
               nxt.blink_timer = blink_t + 10'd1;
            end else if (cur.mode == efc_pkg::MODE_MOVE) begin
               led_t = cur.motion_led;
               if (blink_t == cfg.blink) begin
                  led_t   = ~led_t;
                  blink_t = 10'd0;
               end
               nxt.motion_led  = led_t;
               nxt.blink_timer = blink_t + 10'd1;
               if (go_down) begin
                  nxt.down = 1'b1;
                  if (travel_due) begin
                     nxt.floor_no = cur.floor_no - 2'd1;
                     travel_t     = 14'd0;
                  end
               end else if (go_up) begin
                  nxt.down = 1'b0;
                  if (travel_due) begin
                     nxt.floor_no = cur.floor_no + 2'd1;
                     travel_t     = 14'd0;
                  end
               end else begin
                  // Arrival: take the queued floor, open the door.
                  if (cur.pending != 2'd0) begin
                     nxt.target  = cur.pending;
                     nxt.pending = 2'd0;
                  end
                  nxt.motion_led  = 1'b0;
                  nxt.blink_timer = 10'd0;
                  travel_t        = 14'd0;
               end
               nxt.travel_timer = travel_t + 14'd1;
            end
         end
         efc_pkg::OP_CALL: begin
            if (call_ok) begin
               if (cur.mode == efc_pkg::MODE_IDLE && cur.floor_no != call_floor) begin
                  nxt.target = call_floor;
               end else if (cur.pending == 2'd0 && cur.target != call_floor &&
                            cur.mode != efc_pkg::MODE_IDLE) begin
                  nxt.pending = call_floor;
               end
            end
         end
         efc_pkg::OP_MODE: begin
            if (cur.mode != efc_pkg::MODE_SPEED) nxt.saved_mode = cur.mode;
         end
         efc_pkg::OP_ADC: begin
            if (cur.mode == efc_pkg::MODE_SPEED) begin
               nxt.speed = (adc_sample < efc_pkg::ADC_MIN) ? 3'd0 : speed_pick;
            end
         end
         default: nxt = cur;
      endcase
   end

   // Displayed digit after the update.
   always_comb begin
      case (mode_nxt)
         efc_pkg::MODE_IDLE: shown = nxt.floor_no;
         efc_pkg::MODE_MOVE: shown = nxt.down ? (nxt.floor_no - 2'd1) : nxt.floor_no;
         default:            shown = 2'd0;
      endcase
   end

endmodule

// ===== design/elevator_floor_controller.sv =====
// Elevator floor controller. An input transfer passes the input register, then the
// single-pass update into the state/result registers, to become its result.
// Throughput: one event per cycle unless the result channel stalls; the update of one
// event is one level of logic between the input register and the state registers.
// Reset (synchronous, active high): car idle at floor 1, speed 6, config at defaults,
// both pipeline stages empty.
`timescale 1ns / 1ps

module elevator_floor_controller #(
   parameter int NUM_FLOORS = 3
) (
   input  logic        clock,
   input  logic        reset,
   // Event input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_call_floor,
   input  logic [9:0]  req_adc_sample,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_mode,
   output logic [1:0]  rsp_current_floor,
   output logic [1:0]  rsp_target_floor,
   output logic [1:0]  rsp_pending_floor,
   output logic        rsp_door_led,
   output logic        rsp_motion_led,
   output logic        rsp_going_down,
   output logic [2:0]  rsp_speed_index,
   output logic [1:0]  rsp_shown_floor,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   efc_pkg::cfg_type   cfg;
   efc_pkg::state_type state_ff;
   efc_pkg::state_type state_in;
   efc_pkg::state_type state_nxt;
   logic [1:0]         shown_nxt;
   logic [1:0]         shown_ff;
   logic [1:0]         shown_in;

   // Input stage
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [1:0]         in_opcode_ff;
   logic [1:0]         in_call_floor_ff;
   logic [9:0]         in_adc_sample_ff;
   logic               req_take;

   // Result stage
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               advance;

   efc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   efc_step #(
      .NUM_FLOORS (NUM_FLOORS)
   ) u_step (
      .cur        (state_ff),
      .cfg        (cfg),
      .opcode     (in_opcode_ff),
      .call_floor (in_call_floor_ff),
      .adc_sample (in_adc_sample_ff),
      .nxt        (state_nxt),
      .shown      (shown_nxt)
   );

   // Advance the held event into the result stage when the result slot is free
   // or its current result transfers in this cycle.
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   // Stall the input only while the input stage is full and cannot advance.
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // The state registers double as the result payload: they change only when a
   // new event advances, which cannot happen while a result is stalled.
   assign state_in = advance ? state_nxt : state_ff;
   assign shown_in = advance ? shown_nxt : shown_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= efc_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff     <= req_opcode;
         in_call_floor_ff <= req_call_floor;
         in_adc_sample_ff <= req_adc_sample;
      end
      shown_ff <= shown_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = state_ff.mode;
   assign rsp_current_floor = state_ff.floor_no;
   assign rsp_target_floor  = state_ff.target;
   assign rsp_pending_floor = state_ff.pending;
   assign rsp_door_led      = state_ff.door_led;
   assign rsp_motion_led    = state_ff.motion_led;
   assign rsp_going_down    = state_ff.down;
   assign rsp_speed_index   = state_ff.speed;
   assign rsp_shown_floor   = shown_ff;

endmodule

// ===== design/efc_checker.sv =====
// Port-level checks of the elevator floor controller, bound to the top level.
// Depends on efc_pkg for the mode codes and on the top level's port names.
`timescale 1ns / 1ps

module efc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_mode,
   input logic [1:0] rsp_current_floor,
   input logic [2:0] rsp_speed_index,
   input logic [1:0] rsp_shown_floor
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mode) &&
         $stable(rsp_current_floor) && $stable(rsp_speed_index))
      else $error("stalled result changed");

   // A fresh result always traces back to an earlier input transfer.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input transfer");

   // The input only stalls behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with a free result slot");

   // Idle shows the current floor.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == efc_pkg::MODE_IDLE |-> rsp_shown_floor == rsp_current_floor)
      else $error("idle display does not match the floor");

   // Door phases and speed set show no digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == efc_pkg::MODE_CLOSE || rsp_mode == efc_pkg::MODE_OPEN ||
                    rsp_mode == efc_pkg::MODE_SPEED) |-> rsp_shown_floor == 2'd0)
      else $error("digit shown while doors move or in speed set");

endmodule

bind elevator_floor_controller efc_checker u_efc_checker (.*);

// ===== test/elevator_floor_controller_tb.sv =====
// Self-checking testbench for elevator_floor_controller: random and directed car events
// against a cycle-free model of the car, with stalls on both channels.
// Depends on efc_pkg (mode, opcode and register names) and the controller RTL.
`timescale 1ns / 1ps

module elevator_floor_controller_tb;

   localparam int CAR_FLOORS   = 3;
   localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
   localparam int SETTLE_CYCLES = 4;    // margin to let the pipeline drain

   typedef struct {
      efc_pkg::opcode_type op;
      logic [1:0]          floor_no;
      logic [9:0]          adc;
   } car_event_type;

   typedef struct {
      logic [2:0] mode;
      logic [1:0] current_floor;
      logic [1:0] target_floor;
      logic [1:0] pending_floor;
      logic       door_led;
      logic       motion_led;
      logic       going_down;
      logic [2:0] speed_index;
      logic [1:0] shown_floor;
   } car_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [1:0]  req_call_floor = '0;
   logic [9:0]  req_adc_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_mode;
   logic [1:0]  rsp_current_floor;
   logic [1:0]  rsp_target_floor;
   logic [1:0]  rsp_pending_floor;
   logic        rsp_door_led;
   logic        rsp_motion_led;
   logic        rsp_going_down;
   logic [2:0]  rsp_speed_index;
   logic [1:0]  rsp_shown_floor;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   elevator_floor_controller i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_call_floor    (req_call_floor),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mode          (rsp_mode),
      .rsp_current_floor (rsp_current_floor),
      .rsp_target_floor  (rsp_target_floor),
      .rsp_pending_floor (rsp_pending_floor),
      .rsp_door_led      (rsp_door_led),
      .rsp_motion_led    (rsp_motion_led),
      .rsp_going_down    (rsp_going_down),
      .rsp_speed_index   (rsp_speed_index),
      .rsp_shown_floor   (rsp_shown_floor),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Car model: its own copy of timing registers and car state.
   logic [11:0]       cfg_door_delay;
   logic [9:0]        cfg_blink;
   logic [11:0]       cfg_move_base;
   logic [9:0]        cfg_move_step;
   efc_pkg::mode_type car_mode;
   efc_pkg::mode_type car_saved_mode;
   logic [1:0]        car_floor;
   logic [1:0]        car_target;
   logic [1:0]        car_pending;
   logic [11:0]       door_count;
   logic [9:0]        blink_count;
   logic [13:0]       travel_count;
   logic              car_down;
   logic              door_lamp;
   logic              motion_lamp;
   logic [2:0]        car_speed;

   car_event_type pending_events[$];  // events waiting to be driven
   car_view_type  due_views[$];       // car readings owed by the block, oldest first
   car_event_type req_item;           // event currently on the request port
   bit            req_took;           // request transfer seen at the last rising edge
   int            req_gap;
   int            rsp_hold;
   int            req_gap_pct;
   int            rsp_gap_pct;
   int            mismatches;
   int            quiet_cycles;
   car_view_type  want;

   // Advance the car model by one event and record the reading it must produce.
   task automatic step_car(input car_event_type ev);
      int           period;
      car_view_type view;
      period = int'(cfg_move_base) + int'(cfg_move_step) * int'(car_speed);
      case (ev.op)
         efc_pkg::OP_TICK: begin
            if (car_mode == efc_pkg::MODE_CLOSE || car_mode == efc_pkg::MODE_OPEN) begin
               // Door phase: end it when the timer hits the delay, then blink.
               if (door_count == cfg_door_delay) begin
                  if (car_mode == efc_pkg::MODE_OPEN)
                     car_mode = (car_floor != car_target) ? efc_pkg::MODE_CLOSE
                                                          : efc_pkg::MODE_IDLE;
                  else
                     car_mode = efc_pkg::MODE_MOVE;
                  door_lamp = 1'b0;
                  blink_count = '0;
                  door_count = '0;
               end
               if (blink_count == cfg_blink) begin
                  door_lamp = ~door_lamp;
                  blink_count = '0;
               end
               door_count = door_count + 12'd1;
               blink_count = blink_count + 10'd1;
            end else if (car_mode == efc_pkg::MODE_MOVE) begin
               if (blink_count == cfg_blink) begin
                  motion_lamp = ~motion_lamp;
                  blink_count = '0;
               end
               blink_count = blink_count + 10'd1;
               if (car_target != 2'd0 && car_target < car_floor) begin
                  car_down = 1'b1;
                  if (int'(travel_count) >= period) begin
                     car_floor = car_floor - 2'd1;
                     travel_count = '0;
                  end
               end else if (car_target > car_floor) begin
                  car_down = 1'b0;
                  if (int'(travel_count) >= period) begin
                     car_floor = car_floor + 2'd1;
                     travel_count = '0;
                  end
               end else begin
                  // Arrived: promote the queued call and open the doors.
                  if (car_pending != 2'd0) begin
                     car_target = car_pending;
                     car_pending = 2'd0;
                  end
                  car_mode = efc_pkg::MODE_OPEN;
                  motion_lamp = 1'b0;
                  travel_count = '0;
                  blink_count = '0;
               end
               travel_count = travel_count + 14'd1;
            end
         end
         efc_pkg::OP_CALL: begin
            if (ev.floor_no != 2'd0 && int'(ev.floor_no) <= CAR_FLOORS) begin
               if (car_mode == efc_pkg::MODE_IDLE && car_floor != ev.floor_no) begin
                  car_target = ev.floor_no;
                  car_mode = efc_pkg::MODE_CLOSE;
               end else if (car_pending == 2'd0 && car_target != ev.floor_no &&
                            car_mode != efc_pkg::MODE_IDLE) begin
                  car_pending = ev.floor_no;
               end
            end
         end
         efc_pkg::OP_MODE: begin
            if (car_mode != efc_pkg::MODE_SPEED) begin
               car_saved_mode = car_mode;
               car_mode = efc_pkg::MODE_SPEED;
            end else begin
               car_mode = car_saved_mode;
            end
         end
         efc_pkg::OP_ADC: begin
            if (car_mode == efc_pkg::MODE_SPEED)
               car_speed = (ev.adc < 10'd5) ? 3'd0 : 3'((2 * int'(ev.adc) + 340) / 341);
         end
         default: begin
         end
      endcase
      view.mode = car_mode;
      view.current_floor = car_floor;
      view.target_floor = car_target;
      view.pending_floor = car_pending;
      view.door_led = door_lamp;
      view.motion_led = motion_lamp;
      view.going_down = car_down;
      view.speed_index = car_speed;
      if (car_mode == efc_pkg::MODE_IDLE)
         view.shown_floor = car_floor;
      else if (car_mode == efc_pkg::MODE_MOVE)
         view.shown_floor = car_down ? car_floor - 2'd1 : car_floor;
      else
         view.shown_floor = 2'd0;
      due_views.push_back(view);
   endtask

   function automatic void check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatches++;
      end
   endfunction

   function automatic void add_event(input efc_pkg::opcode_type op, input logic [1:0] floor_no,
                                     input logic [9:0] adc);
      car_event_type ev;
      ev.op = op;
      ev.floor_no = floor_no;
      ev.adc = adc;
      pending_events.push_back(ev);
   endfunction

   // Bias samples toward the low threshold and full scale now and then.
   function automatic logic [9:0] pick_adc();
      case ($urandom_range(0, 5))
         0: return 10'($urandom_range(0, 8));
         1: return 10'd1023;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // Mostly ticks and calls so trips run to completion; speed-set visits are
   // whole button/sample/button sequences; lone buttons and stray samples are noise.
   task automatic queue_random_events(input int count);
      int made;
      int pick;
      int samples;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            add_event(efc_pkg::OP_TICK, 2'($urandom), pick_adc());
            made++;
         end else if (pick < 80) begin
            add_event(efc_pkg::OP_CALL,
                      ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                      pick_adc());
            made++;
         end else if (pick < 90) begin
            samples = $urandom_range(1, 3);
            add_event(efc_pkg::OP_MODE, 2'($urandom), pick_adc());
            repeat (samples) add_event(efc_pkg::OP_ADC, 2'($urandom), pick_adc());
            add_event(efc_pkg::OP_MODE, 2'($urandom), pick_adc());
            made += samples + 2;
         end else if (pick < 95) begin
            add_event(efc_pkg::OP_MODE, 2'($urandom), pick_adc());
         end else begin
            add_event(efc_pkg::OP_ADC, 2'($urandom), pick_adc());
         end
      end
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         efc_pkg::REG_DOOR_DELAY: cfg_door_delay = value[11:0];
         efc_pkg::REG_BLINK:      cfg_blink = value[9:0];
         efc_pkg::REG_MOVE_BASE:  cfg_move_base = value[11:0];
         efc_pkg::REG_MOVE_STEP:  cfg_move_step = value[9:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_timing(input int door, input int blink, input int base, input int step);
      write_csr(efc_pkg::REG_DOOR_DELAY, door);
      write_csr(efc_pkg::REG_BLINK, blink);
      write_csr(efc_pkg::REG_MOVE_BASE, base);
      write_csr(efc_pkg::REG_MOVE_STEP, step);
   endtask

   // Hold until every event is driven and every reading has come back,
   // then let the pipeline drain.
   task automatic wait_until_quiet();
      while (pending_events.size() != 0 || req_valid || due_views.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: note the transfer at the rising edge, act on it at the falling edge.
   always @(posedge clock) begin
      req_took = req_valid && !req_stall;
   end

   always @(negedge clock) begin
      if (req_took)
         step_car(req_item);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // Hold the stalled transfer as it is.
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_gap = $urandom_range(0, 6);
         req_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
         req_item = pending_events.pop_front();
         req_opcode <= req_item.op;
         req_call_floor <= req_item.floor_no;
         req_adc_sample <= req_item.adc;
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result monitor: stall in random bursts, compare each transfer with the oldest reading.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if (rsp_gap_pct != 0 && $urandom_range(0, 99) < rsp_gap_pct) begin
         rsp_hold = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_views.size() == 0) begin
            $error("car reading transferred with none outstanding");
            mismatches++;
         end else begin
            want = due_views.pop_front();
            check_field("mode", want.mode, rsp_mode);
            check_field("current_floor", want.current_floor, rsp_current_floor);
            check_field("target_floor", want.target_floor, rsp_target_floor);
            check_field("pending_floor", want.pending_floor, rsp_pending_floor);
            check_field("door_led", want.door_led, rsp_door_led);
            check_field("motion_led", want.motion_led, rsp_motion_led);
            check_field("going_down", want.going_down, rsp_going_down);
            check_field("speed_index", want.speed_index, rsp_speed_index);
            check_field("shown_floor", want.shown_floor, rsp_shown_floor);
         end
      end
      // Watchdog: any transfer on either channel restarts the count.
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("elevator_floor_controller: mismatch");
            $finish;
         end
      end
   end

   initial begin
      // Car model at its reset state.
      cfg_door_delay = 12'd1500;
      cfg_blink = 10'd200;
      cfg_move_base = 12'd400;
      cfg_move_step = 10'd100;
      car_mode = efc_pkg::MODE_IDLE;
      car_saved_mode = efc_pkg::MODE_IDLE;
      car_floor = 2'd1;
      car_target = 2'd0;
      car_pending = 2'd0;
      door_count = '0;
      blink_count = '0;
      travel_count = '0;
      car_down = 1'b0;
      door_lamp = 1'b0;
      motion_lamp = 1'b0;
      car_speed = 3'd6;
      req_took = 1'b0;
      req_gap = 0;
      rsp_hold = 0;
      req_gap_pct = 15;
      rsp_gap_pct = 15;
      mismatches = 0;
      quiet_cycles = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, at reset timing: idle tick, stray sample, floor zero, call to
      // own floor, frozen tick in speed set, sample thresholds and full scale,
      // then start a trip, queue a call and repeat the target.
      add_event(efc_pkg::OP_TICK, 2'd0, 10'd0);
      add_event(efc_pkg::OP_ADC, 2'd3, 10'd1023);
      add_event(efc_pkg::OP_CALL, 2'd0, 10'd0);
      add_event(efc_pkg::OP_CALL, 2'd1, 10'd0);
      add_event(efc_pkg::OP_MODE, 2'd0, 10'd0);
      add_event(efc_pkg::OP_TICK, 2'd0, 10'd0);
      add_event(efc_pkg::OP_ADC, 2'd0, 10'd0);
      add_event(efc_pkg::OP_ADC, 2'd0, 10'd4);
      add_event(efc_pkg::OP_ADC, 2'd0, 10'd5);
      add_event(efc_pkg::OP_ADC, 2'd0, 10'd170);
      add_event(efc_pkg::OP_ADC, 2'd0, 10'd171);
      add_event(efc_pkg::OP_ADC, 2'd0, 10'd1023);
      add_event(efc_pkg::OP_MODE, 2'd0, 10'd0);
      add_event(efc_pkg::OP_CALL, 2'd3, 10'd0);
      add_event(efc_pkg::OP_CALL, 2'd2, 10'd0);
      add_event(efc_pkg::OP_CALL, 2'd3, 10'd0);
      wait_until_quiet();

      // Shortest timing: run the queued trip up, turn around and head down.
      // Door delay and blink only grow from here so no timer is left past its limit.
      set_timing(1, 1, 1, 0);
      repeat (12) add_event(efc_pkg::OP_TICK, 2'd0, 10'd0);
      queue_random_events(120);
      wait_until_quiet();

      set_timing(2, 1, 2, 1);
      req_gap_pct = 35;
      rsp_gap_pct = 10;
      queue_random_events(120);
      wait_until_quiet();

      set_timing(3, 2, 1, 2);
      req_gap_pct = 0;
      rsp_gap_pct = 35;
      queue_random_events(120);
      wait_until_quiet();

      set_timing(4, 3, 3, 1);
      req_gap_pct = 10;
      rsp_gap_pct = 10;
      queue_random_events(120);
      wait_until_quiet();

      // Longest timing, no idling on either side for the tail of the run.
      set_timing(4095, 1023, 4095, 1023);
      req_gap_pct = 0;
      rsp_gap_pct = 0;
      queue_random_events(50);
      wait_until_quiet();

      if (mismatches == 0)
         $display("elevator_floor_controller: match");
      else
         $display("elevator_floor_controller: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/efc_pkg.sv
design/efc_csr.sv
design/efc_step.sv
design/elevator_floor_controller.sv
design/efc_checker.sv
test/elevator_floor_controller_tb.sv
